// ===== sv/local_response_norm_top_assert.svh =====
// ----------------------------------------------------------------------------
// local_response_norm_top_assert
// assertion macros shared by the normalization block
// ----------------------------------------------------------------------------
`ifndef LOCAL_RESPONSE_NORM_TOP_ASSERT_SVH
`define LOCAL_RESPONSE_NORM_TOP_ASSERT_SVH

// same-cycle implication, checked outside reset
`define LRN_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lrn check failed");

// next-cycle implication, checked outside reset
`define LRN_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lrn check failed");

`endif

// ===== sv/lrn_pkg.sv =====
// ----------------------------------------------------------------------------
// lrn_pkg
// shared constants, types and helper functions of the normalization block
// ----------------------------------------------------------------------------
package lrn_pkg;

  // default sizes
  localparam int MAX_WINDOW_DEF   = 16;
  localparam int MAX_CHANNELS_DEF = 4096;

  // field and port widths
  localparam int SAMPLE_W = 16;
  localparam int CFG_DW   = 32;
  localparam int CFG_IW   = 2;

  // register indexes
  localparam logic [CFG_IW-1:0] REG_WINDOW = 2'd0;
  localparam logic [CFG_IW-1:0] REG_ALPHA  = 2'd1;
  localparam logic [CFG_IW-1:0] REG_BETA   = 2'd2;
  localparam logic [CFG_IW-1:0] REG_BIAS   = 2'd3;

  // register reset values
  localparam logic [4:0]  WINDOW_RST = 5'd5;
  localparam logic [31:0] ALPHA_RST  = 32'd429497;
  localparam logic [15:0] BETA_RST   = 16'd3072;
  localparam logic [23:0] BIAS_RST   = 24'd65536;

  // sequencer states
  typedef enum logic [13:0] {
    ST_IDLE  = 14'h0001,
    ST_SQ_IN = 14'h0002,
    ST_CHECK = 14'h0004,
    ST_MUL_A = 14'h0008,
    ST_DIV   = 14'h0010,
    ST_BASE  = 14'h0020,
    ST_NORM  = 14'h0040,
    ST_LOG   = 14'h0080,
    ST_POW   = 14'h0100,
    ST_EXP   = 14'h0200,
    ST_SCALE = 14'h0400,
    ST_ROUND = 14'h0800,
    ST_EMIT  = 14'h1000,
    ST_SUB   = 14'h2000
  } state_t;

  typedef logic [15:0][31:0] root_tab_t;

  // integer square root, used at elaboration only
  function automatic logic [63:0] isqrt64(input logic [63:0] n_in);
    logic [63:0] n;
    logic [63:0] r;
    logic [63:0] bt;
    n  = n_in;
    r  = 64'd0;
    bt = 64'd1 << 62;
    for (int i = 0; i < 32; i++) begin
      if (bt != 64'd0) begin
        if (n >= r + bt) begin
          n = n - (r + bt);
          r = (r >> 1) + bt;
        end else begin
          r = r >> 1;
        end
        bt = bt >> 2;
      end
    end
    return r;
  endfunction

  // entry i holds 2^(2^-(i+1)) in Q2.30, each a root of the one before
  function automatic root_tab_t root_table();
    root_tab_t   t;
    logic [63:0] prev;
    prev = 64'd1 << 31;
    for (int k = 0; k < 16; k++) begin
      prev = isqrt64(prev << 30);
      t[k] = prev[31:0];
    end
    return t;
  endfunction

  // magnitude of a signed 16-bit value
  function automatic logic [16:0] mag17(input logic [15:0] v);
    return v[15] ? (17'd0 - {1'b1, v}) : {1'b0, v};
  endfunction

  // full-scale value carrying the sign of v, zero for zero
  function automatic logic [15:0] sat_sign(input logic [15:0] v);
    if (v[15]) return 16'h8000;
    if (v != 16'd0) return 16'h7fff;
    return 16'h0000;
  endfunction

endpackage

// ===== sv/local_response_norm_top.sv =====
// ----------------------------------------------------------------------------
// local_response_norm_top
// local response normalization across the channels of one pixel
// ----------------------------------------------------------------------------
// in_*  : one channel value per beat, in channel order, in_tlast on the final
//         channel of the pixel.
// out_* : normalized values in channel order, out_tlast on the pixel's last.
// cfg_* : register writes, only while no pixel work is pending.
// Output c leaves once channel c+size/2 has arrived; the rest are flushed on
// the last channel, so one input beat gives zero to several output beats.
// Each output runs on one shared 33x33 multiplier under a sequencer, with a
// bit-serial divide whose length is the sum width minus 8 (27 by default)
// and a leading-one search, one bit a cycle.
// in_tready is high only while the sequencer is idle, also while an output
// beat still waits in the output register.
// A stalled receiver holds the sequencer at its emit step until the output
// register frees up; no result is dropped.
// Reset (rst_n low, synchronous) restores the default registers and starts a
// fresh pixel; a window size write also starts a fresh pixel.
// ----------------------------------------------------------------------------
module local_response_norm_top #(
  parameter int MAX_WINDOW   = lrn_pkg::MAX_WINDOW_DEF,
  parameter int MAX_CHANNELS = lrn_pkg::MAX_CHANNELS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  // in_tdata: [15:0] sample_value
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [15:0]                 in_tdata,
  input  logic                        in_tlast,
  // out_tdata: [15:0] normalized_value
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [15:0]                 out_tdata,
  output logic                        out_tlast,
  input  logic                        cfg_we,
  input  logic [lrn_pkg::CFG_IW-1:0]  cfg_index,
  input  logic [lrn_pkg::CFG_DW-1:0]  cfg_wdata
);

  `include "local_response_norm_top_assert.svh"

  localparam int RAW   = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int RDEP  = 1 << RAW;
  localparam int CW    = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int NW    = CW + 1;
  localparam int WW    = $clog2(MAX_WINDOW + 1) + 1;
  localparam int EW    = ((NW > WW) ? NW : WW) + 1;
  localparam int SUMW  = 31 + $clog2(MAX_WINDOW);
  localparam int QW    = SUMW - 8;
  localparam int CNTW  = $clog2(QW);
  localparam lrn_pkg::root_tab_t ROOT_TAB = lrn_pkg::root_table();

  // configuration registers
  logic [4:0]  window_r;
  logic [31:0] alpha_r;
  logic [15:0] beta_r;
  logic [23:0] bias_r;

  // sequencer and datapath registers
  lrn_pkg::state_t st_r, st_nxt;
  logic [15:0]        sample_r, sample_nxt;
  logic               last_r, last_nxt;
  logic [SUMW-1:0]    sum_r, sum_nxt;
  logic [CW-1:0]      chan_r, chan_nxt;
  logic [NW-1:0]      next_r, next_nxt;
  logic [15:0]        x_r, x_nxt;
  logic [QW-1:0]      dvd_r, dvd_nxt;
  logic [WW-1:0]      rem_r, rem_nxt;
  logic [CNTW-1:0]    cnt_r, cnt_nxt;
  logic [31:0]        mant_r, mant_nxt;
  logic [4:0]         n_r, n_nxt;
  logic [15:0]        frac_r, frac_nxt;
  logic signed [23:0] ip_r, ip_nxt;
  logic [15:0]        f_r, f_nxt;
  logic [31:0]        m_r, m_nxt;
  logic [47:0]        prod_r, prod_nxt;
  logic [15:0]        res_r, res_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [15:0]        out_data_r, out_data_nxt;
  logic               out_last_r, out_last_nxt;

  // sample ring
  logic [15:0]        ring_r [RDEP];
  logic [15:0]        rd_data_r;
  logic [RAW-1:0]     rd_addr;

  // shared multiplier
  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] mul_p;
  assign mul_p = mul_a * mul_b;

  // effective window and its halves
  logic [WW-1:0] win_w, half_lo, half_hi;
  always_comb begin
    if (window_r == 5'd0) begin
      win_w = WW'(1);
    end else if (32'(window_r) > 32'(MAX_WINDOW)) begin
      win_w = WW'(MAX_WINDOW);
    end else begin
      win_w = WW'(window_r);
    end
    half_lo = (win_w - WW'(1)) >> 1;
    half_hi = win_w >> 1;
  end

  // helpers for the sequencer
  logic [16:0]        samp_mag, x_mag, rd_mag;
  logic               out_go;
  logic [WW:0]        rem_sh;
  logic               q_bit;
  logic [31:0]        base;
  logic [32:0]        sq;
  logic [21:0]        lg;
  logic [5:0]         lg_int;
  logic signed [65:0] neg_p;
  logic signed [23:0] sh_full;
  logic [47:0]        shifted;
  logic [48:0]        rnd;
  logic [48:0]        rmag;
  logic [NW-1:0]      sub_ch;
  logic               more;

  assign samp_mag = lrn_pkg::mag17(sample_r);
  assign x_mag    = lrn_pkg::mag17(x_r);
  assign rd_mag   = lrn_pkg::mag17(rd_data_r);
  assign rem_sh   = {rem_r, dvd_r[QW-1]};
  assign q_bit    = (rem_sh >= (WW+1)'(win_w));
  assign base     = 32'(bias_r) + 32'(dvd_r);
  assign sq       = mul_p[63:31];
  assign lg_int   = 6'({1'b0, n_r}) - 6'd16;
  assign lg       = {lg_int, frac_r};
  assign neg_p    = -mul_p;
  assign sh_full  = 24'sd29 - ip_r;
  assign shifted  = prod_r >> sh_full[5:0];
  assign rnd      = ({1'b0, shifted} + 49'd1) >> 1;
  assign rmag     = (ip_r < -24'sd32) ? 49'd0 : rnd;
  assign sub_ch   = next_r - NW'(half_lo);
  assign out_go   = !out_valid_r || out_tready;
  assign more     = (EW'(next_r) <= EW'(chan_r)) &&
                    ((EW'(next_r) + EW'(half_hi) <= EW'(chan_r)) || last_r);

  // sequencer
  always_comb begin
    st_nxt        = st_r;
    sample_nxt    = sample_r;
    last_nxt      = last_r;
    sum_nxt       = sum_r;
    chan_nxt      = chan_r;
    next_nxt      = next_r;
    x_nxt         = x_r;
    dvd_nxt       = dvd_r;
    rem_nxt       = rem_r;
    cnt_nxt       = cnt_r;
    mant_nxt      = mant_r;
    n_nxt         = n_r;
    frac_nxt      = frac_r;
    ip_nxt        = ip_r;
    f_nxt         = f_r;
    m_nxt         = m_r;
    prod_nxt      = prod_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    out_last_nxt  = out_last_r;
    mul_a         = '0;
    mul_b         = '0;
    rd_addr       = RAW'(next_r);

    case (st_r)
      lrn_pkg::ST_IDLE: begin
        if (in_tvalid) begin
          sample_nxt = in_tdata;
          last_nxt   = in_tlast || (chan_r == CW'(MAX_CHANNELS - 1));
          st_nxt     = lrn_pkg::ST_SQ_IN;
        end
      end
      // add the new square into the window sum
      lrn_pkg::ST_SQ_IN: begin
        mul_a   = {16'd0, samp_mag};
        mul_b   = {16'd0, samp_mag};
        sum_nxt = sum_r + mul_p[SUMW-1:0];
        st_nxt  = lrn_pkg::ST_CHECK;
      end
      // decide whether another output is due, fetch its sample
      lrn_pkg::ST_CHECK: begin
        rd_addr = RAW'(next_r);
        if (more) begin
          st_nxt = lrn_pkg::ST_MUL_A;
        end else begin
          if (last_r) begin
            sum_nxt  = '0;
            chan_nxt = '0;
            next_nxt = '0;
          end else begin
            chan_nxt = chan_r + CW'(1);
          end
          st_nxt = lrn_pkg::ST_IDLE;
        end
      end
      // alpha times sum, upper part goes to the divider
      lrn_pkg::ST_MUL_A: begin
        x_nxt   = rd_data_r;
        mul_a   = {1'b0, alpha_r};
        mul_b   = 33'(sum_r[SUMW-1:8]);
        dvd_nxt = mul_p[32+QW-1:32];
        rem_nxt = '0;
        cnt_nxt = '0;
        st_nxt  = lrn_pkg::ST_DIV;
      end
      // restoring divide by the window size, one bit a cycle
      lrn_pkg::ST_DIV: begin
        rem_nxt = q_bit ? WW'(rem_sh - (WW+1)'(win_w)) : WW'(rem_sh);
        dvd_nxt = {dvd_r[QW-2:0], q_bit};
        cnt_nxt = cnt_r + CNTW'(1);
        if (cnt_r == CNTW'(QW - 1)) st_nxt = lrn_pkg::ST_BASE;
      end
      // base = bias + scaled sum
      lrn_pkg::ST_BASE: begin
        if (base == 32'd0) begin
          res_nxt = (beta_r == 16'd0) ? x_r : lrn_pkg::sat_sign(x_r);
          st_nxt  = lrn_pkg::ST_EMIT;
        end else begin
          mant_nxt = base;
          n_nxt    = 5'd31;
          st_nxt   = lrn_pkg::ST_NORM;
        end
      end
      // leading-one search
      lrn_pkg::ST_NORM: begin
        if (mant_r[31]) begin
          cnt_nxt  = '0;
          frac_nxt = '0;
          st_nxt   = lrn_pkg::ST_LOG;
        end else begin
          mant_nxt = mant_r << 1;
          n_nxt    = n_r - 5'd1;
        end
      end
      // log2 fraction by repeated squaring
      lrn_pkg::ST_LOG: begin
        mul_a = {1'b0, mant_r};
        mul_b = {1'b0, mant_r};
        if (sq[32]) begin
          mant_nxt = sq[32:1];
          frac_nxt = {frac_r[14:0], 1'b1};
        end else begin
          mant_nxt = sq[31:0];
          frac_nxt = {frac_r[14:0], 1'b0};
        end
        cnt_nxt = cnt_r + CNTW'(1);
        if (cnt_r == CNTW'(15)) st_nxt = lrn_pkg::ST_POW;
      end
      // exponent = -beta * log2(base)
      lrn_pkg::ST_POW: begin
        mul_a   = {17'd0, beta_r};
        mul_b   = {{11{lg[21]}}, lg};
        ip_nxt  = neg_p[51:28];
        f_nxt   = neg_p[27:12];
        m_nxt   = 32'd1 << 30;
        cnt_nxt = '0;
        st_nxt  = lrn_pkg::ST_EXP;
      end
      // 2^fraction from the root table
      lrn_pkg::ST_EXP: begin
        mul_a = {1'b0, m_r};
        mul_b = {1'b0, ROOT_TAB[cnt_r[3:0]]};
        if (f_r[4'd15 - cnt_r[3:0]]) m_nxt = mul_p[61:30];
        cnt_nxt = cnt_r + CNTW'(1);
        if (cnt_r == CNTW'(15)) st_nxt = lrn_pkg::ST_SCALE;
      end
      // magnitude times gain
      lrn_pkg::ST_SCALE: begin
        mul_a    = {16'd0, x_mag};
        mul_b    = {1'b0, m_r};
        prod_nxt = mul_p[47:0];
        st_nxt   = lrn_pkg::ST_ROUND;
      end
      // shift, round half up, sign and saturate
      lrn_pkg::ST_ROUND: begin
        if (x_mag == 17'd0) begin
          res_nxt = 16'd0;
        end else if (ip_r >= 24'sd16) begin
          res_nxt = lrn_pkg::sat_sign(x_r);
        end else if (x_r[15]) begin
          res_nxt = (rmag >= 49'd32768) ? 16'h8000 : 16'd0 - rmag[15:0];
        end else begin
          res_nxt = (rmag >= 49'd32767) ? 16'h7fff : rmag[15:0];
        end
        st_nxt = lrn_pkg::ST_EMIT;
      end
      // hand the result to the output register, fetch the leaving sample
      lrn_pkg::ST_EMIT: begin
        rd_addr = RAW'(sub_ch);
        if (out_go) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = res_r;
          out_last_nxt  = last_r && (next_r == NW'(chan_r));
          if (next_r >= NW'(half_lo)) begin
            st_nxt = lrn_pkg::ST_SUB;
          end else begin
            next_nxt = next_r + NW'(1);
            st_nxt   = lrn_pkg::ST_CHECK;
          end
        end
      end
      // drop the leaving square from the window sum
      lrn_pkg::ST_SUB: begin
        mul_a    = {16'd0, rd_mag};
        mul_b    = {16'd0, rd_mag};
        sum_nxt  = sum_r - mul_p[SUMW-1:0];
        next_nxt = next_r + NW'(1);
        st_nxt   = lrn_pkg::ST_CHECK;
      end
      default: begin
        st_nxt = lrn_pkg::ST_IDLE;
      end
    endcase

    // a window size write starts a fresh pixel
    if (cfg_we && cfg_index == lrn_pkg::REG_WINDOW) begin
      sum_nxt  = '0;
      chan_nxt = '0;
      next_nxt = '0;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= lrn_pkg::ST_IDLE;
      sum_r       <= '0;
      chan_r      <= '0;
      next_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      sum_r       <= sum_nxt;
      chan_r      <= chan_nxt;
      next_r      <= next_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // datapath payload
  always_ff @(posedge clk) begin
    sample_r   <= sample_nxt;
    last_r     <= last_nxt;
    x_r        <= x_nxt;
    dvd_r      <= dvd_nxt;
    rem_r      <= rem_nxt;
    cnt_r      <= cnt_nxt;
    mant_r     <= mant_nxt;
    n_r        <= n_nxt;
    frac_r     <= frac_nxt;
    ip_r       <= ip_nxt;
    f_r        <= f_nxt;
    m_r        <= m_nxt;
    prod_r     <= prod_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
    out_last_r <= out_last_nxt;
  end

  // sample ring, one write and one registered read
  always_ff @(posedge clk) begin
    if (st_r == lrn_pkg::ST_IDLE && in_tvalid) ring_r[RAW'(chan_r)] <= in_tdata;
    rd_data_r <= ring_r[rd_addr];
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r <= lrn_pkg::WINDOW_RST;
      alpha_r  <= lrn_pkg::ALPHA_RST;
      beta_r   <= lrn_pkg::BETA_RST;
      bias_r   <= lrn_pkg::BIAS_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        lrn_pkg::REG_WINDOW: window_r <= cfg_wdata[4:0];
        lrn_pkg::REG_ALPHA:  alpha_r  <= cfg_wdata[31:0];
        lrn_pkg::REG_BETA:   beta_r   <= cfg_wdata[15:0];
        lrn_pkg::REG_BIAS:   bias_r   <= cfg_wdata[23:0];
        default: ;
      endcase
    end
  end

  // ports
  assign in_tready  = (st_r == lrn_pkg::ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

  // checks
  `LRN_ASSERT_NXT(a_busy_after_beat, in_tvalid && in_tready, !in_tready)
  `LRN_ASSERT_IMP(a_log_normalized, st_r == lrn_pkg::ST_LOG, mant_r[31])
  `LRN_ASSERT_IMP(a_next_bound, 1'b1, next_r <= NW'(chan_r) + NW'(1))

endmodule
